// ----- hdl/jtgc_pkg.sv -----
`timescale 1ns / 1ps
// jtgc_pkg: shared types and codes for the json token grammar checker
// token and result payloads, token classes and the queue depth; no dependencies

package jtgc_pkg;

    // token kind codes on the input channel
    localparam logic [3:0] TK_NULL   = 4'd0;
    localparam logic [3:0] TK_TRUE   = 4'd1;
    localparam logic [3:0] TK_FALSE  = 4'd2;
    localparam logic [3:0] TK_NUMBER = 4'd3;
    localparam logic [3:0] TK_STRING = 4'd4;
    localparam logic [3:0] TK_LBRACE = 4'd5;
    localparam logic [3:0] TK_RBRACE = 4'd6;
    localparam logic [3:0] TK_LBRACK = 4'd7;
    localparam logic [3:0] TK_RBRACK = 4'd8;
    localparam logic [3:0] TK_COMMA  = 4'd9;
    localparam logic [3:0] TK_COLON  = 4'd10;
    localparam logic [3:0] TK_EOF    = 4'd11;

    // event codes on the result channel
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_NULL      = 4'd1;
    localparam logic [3:0] EV_BOOL      = 4'd2;
    localparam logic [3:0] EV_NUMBER    = 4'd3;
    localparam logic [3:0] EV_STRING    = 4'd4;
    localparam logic [3:0] EV_KEY       = 4'd5;
    localparam logic [3:0] EV_BEGIN_OBJ = 4'd6;
    localparam logic [3:0] EV_END_OBJ   = 4'd7;
    localparam logic [3:0] EV_BEGIN_ARR = 4'd8;
    localparam logic [3:0] EV_END_ARR   = 4'd9;

    // parse status codes
    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    // container kinds held on the stack
    localparam logic KIND_OBJ = 1'b1;
    localparam logic KIND_ARR = 1'b0;

    // entries in the queue between classifier and grammar engine
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] text_offset;
        logic [31:0] text_length;
        logic        start_doc;
    } token_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic        bool_value;
        logic [31:0] event_offset;
        logic [31:0] event_length;
        logic [1:0]  parse_status;
        logic [6:0]  open_depth;
    } result_t;

    typedef enum logic [3:0] {
        OP_SCALAR,
        OP_STRING,
        OP_OPEN_OBJ,
        OP_OPEN_ARR,
        OP_CLOSE_OBJ,
        OP_CLOSE_ARR,
        OP_COMMA,
        OP_COLON,
        OP_EOF,
        OP_BAD
    } tok_op_t;

    typedef struct packed {
        logic        start;
        tok_op_t     op;
        logic [3:0]  value_event;
        logic        bool_value;
        logic        has_text;
        logic [31:0] text_offset;
        logic [31:0] text_length;
    } tok_class_t;

endpackage

// ----- hdl/jtgc_front.sv -----
`timescale 1ns / 1ps
// jtgc_front: classifies an incoming token into a grammar operation
// depends on jtgc_pkg

module jtgc_front (
    input  jtgc_pkg::token_t     tok,
    output jtgc_pkg::tok_class_t cls
);

    always_comb begin
        cls.start       = tok.start_doc;
        cls.op          = jtgc_pkg::OP_BAD;
        cls.value_event = jtgc_pkg::EV_NONE;
        cls.bool_value  = 1'b0;
        cls.has_text    = 1'b0;
        cls.text_offset = tok.text_offset;
        cls.text_length = tok.text_length;
        unique case (tok.token_kind)
            jtgc_pkg::TK_NULL: begin
                cls.op          = jtgc_pkg::OP_SCALAR;
                cls.value_event = jtgc_pkg::EV_NULL;
            end
            jtgc_pkg::TK_TRUE: begin
                cls.op          = jtgc_pkg::OP_SCALAR;
                cls.value_event = jtgc_pkg::EV_BOOL;
                cls.bool_value  = 1'b1;
            end
            jtgc_pkg::TK_FALSE: begin
                cls.op          = jtgc_pkg::OP_SCALAR;
                cls.value_event = jtgc_pkg::EV_BOOL;
            end
            jtgc_pkg::TK_NUMBER: begin
                cls.op          = jtgc_pkg::OP_SCALAR;
                cls.value_event = jtgc_pkg::EV_NUMBER;
                cls.has_text    = 1'b1;
            end
            jtgc_pkg::TK_STRING: begin
                cls.op          = jtgc_pkg::OP_STRING;
                cls.value_event = jtgc_pkg::EV_STRING;
                cls.has_text    = 1'b1;
            end
            jtgc_pkg::TK_LBRACE: begin
                cls.op          = jtgc_pkg::OP_OPEN_OBJ;
                cls.value_event = jtgc_pkg::EV_BEGIN_OBJ;
            end
            jtgc_pkg::TK_LBRACK: begin
                cls.op          = jtgc_pkg::OP_OPEN_ARR;
                cls.value_event = jtgc_pkg::EV_BEGIN_ARR;
            end
            jtgc_pkg::TK_RBRACE: cls.op = jtgc_pkg::OP_CLOSE_OBJ;
            jtgc_pkg::TK_RBRACK: cls.op = jtgc_pkg::OP_CLOSE_ARR;
            jtgc_pkg::TK_COMMA:  cls.op = jtgc_pkg::OP_COMMA;
            jtgc_pkg::TK_COLON:  cls.op = jtgc_pkg::OP_COLON;
            jtgc_pkg::TK_EOF:    cls.op = jtgc_pkg::OP_EOF;
            default:             cls.op = jtgc_pkg::OP_BAD;
        endcase
    end

endmodule

// ----- hdl/jtgc_fifo.sv -----
`timescale 1ns / 1ps
// jtgc_fifo: short queue of classified tokens between front and back
// depends on jtgc_pkg

module jtgc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  jtgc_pkg::tok_class_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output jtgc_pkg::tok_class_t rd_data
);

    localparam int PW = (jtgc_pkg::FIFO_DEPTH > 1) ? $clog2(jtgc_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(jtgc_pkg::FIFO_DEPTH + 1);

    jtgc_pkg::tok_class_t entry_reg [jtgc_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(jtgc_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(jtgc_pkg::FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(jtgc_pkg::FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/jtgc_back.sv -----
`timescale 1ns / 1ps
// jtgc_back: grammar engine with phase, depth and container stack, plus result register
// depends on jtgc_pkg

module jtgc_back #(
    parameter int MAX_NESTING = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    output logic                 head_pop,
    input  jtgc_pkg::tok_class_t head,
    output logic                 m_valid,
    input  logic                 m_ready,
    output jtgc_pkg::result_t    m_data
);

    localparam int DW = $clog2(MAX_NESTING + 2);

    typedef enum logic [2:0] {
        PH_TOP,
        PH_VALUE,
        PH_FIRST_ARR,
        PH_FIRST_KEY,
        PH_KEY,
        PH_COLON,
        PH_AFTER,
        PH_END
    } phase_t;

    phase_t            phase_reg, phase_next, eff_phase;
    logic [DW-1:0]     depth_reg, depth_next, eff_depth;
    logic              active_reg, active_next, eff_active;
    logic [MAX_NESTING:0] stk_reg, stk_next;
    logic              m_valid_reg, m_valid_next;
    jtgc_pkg::result_t m_data_reg, m_data_next;

    logic              out_free;
    logic              ok;
    logic              emit_text;
    logic              val_room;
    logic [3:0]        ev;
    logic              bv;
    logic [1:0]        status;

    assign out_free = !m_valid_reg || m_ready;
    assign head_pop = head_valid && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign eff_depth  = head.start ? '0 : depth_reg;
    assign eff_phase  = head.start ? PH_TOP : phase_reg;
    assign eff_active = head.start || active_reg;
    assign val_room   = (eff_depth <= DW'(MAX_NESTING));

    always_comb begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        active_next  = active_reg;
        stk_next     = stk_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        ok           = 1'b1;
        emit_text    = 1'b0;
        ev           = jtgc_pkg::EV_NONE;
        bv           = 1'b0;
        status       = jtgc_pkg::ST_PROGRESS;

        if (head_pop) begin
            m_valid_next = 1'b1;
            phase_next   = eff_phase;
            depth_next   = eff_depth;
            active_next  = eff_active;
            if (eff_active) begin
                unique case (eff_phase)
                    PH_TOP, PH_VALUE, PH_FIRST_ARR: begin
                        priority if (eff_phase == PH_FIRST_ARR &&
                                     head.op == jtgc_pkg::OP_CLOSE_ARR) begin
                            // empty array closes straight away
                            if (eff_depth != '0 && stk_reg[0] == jtgc_pkg::KIND_ARR) begin
                                depth_next = eff_depth - DW'(1);
                                stk_next   = {1'b0, stk_reg[MAX_NESTING:1]};
                                ev         = jtgc_pkg::EV_END_ARR;
                                phase_next = (eff_depth != DW'(1)) ? PH_AFTER : PH_END;
                            end else begin
                                ok = 1'b0;
                            end
                        end else if (!val_room) begin
                            ok = 1'b0;
                        end else if (head.op == jtgc_pkg::OP_SCALAR ||
                                     head.op == jtgc_pkg::OP_STRING) begin
                            ev         = head.value_event;
                            bv         = head.bool_value;
                            emit_text  = head.has_text;
                            phase_next = (eff_depth != '0) ? PH_AFTER : PH_END;
                        end else if (head.op == jtgc_pkg::OP_OPEN_OBJ) begin
                            ev         = head.value_event;
                            stk_next   = {stk_reg[MAX_NESTING-1:0], jtgc_pkg::KIND_OBJ};
                            depth_next = eff_depth + DW'(1);
                            phase_next = PH_FIRST_KEY;
                        end else if (head.op == jtgc_pkg::OP_OPEN_ARR) begin
                            ev         = head.value_event;
                            stk_next   = {stk_reg[MAX_NESTING-1:0], jtgc_pkg::KIND_ARR};
                            depth_next = eff_depth + DW'(1);
                            phase_next = PH_FIRST_ARR;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_FIRST_KEY, PH_KEY: begin
                        priority if (eff_phase == PH_FIRST_KEY &&
                                     head.op == jtgc_pkg::OP_CLOSE_OBJ) begin
                            // empty object
                            if (eff_depth != '0 && stk_reg[0] == jtgc_pkg::KIND_OBJ) begin
                                depth_next = eff_depth - DW'(1);
                                stk_next   = {1'b0, stk_reg[MAX_NESTING:1]};
                                ev         = jtgc_pkg::EV_END_OBJ;
                                phase_next = (eff_depth != DW'(1)) ? PH_AFTER : PH_END;
                            end else begin
                                ok = 1'b0;
                            end
                        end else if (head.op == jtgc_pkg::OP_STRING) begin
                            ev         = jtgc_pkg::EV_KEY;
                            emit_text  = 1'b1;
                            phase_next = PH_COLON;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_COLON: begin
                        if (head.op == jtgc_pkg::OP_COLON) begin
                            phase_next = PH_VALUE;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_AFTER: begin
                        priority if (head.op == jtgc_pkg::OP_COMMA) begin
                            if (eff_depth == '0) begin
                                ok = 1'b0;
                            end else begin
                                phase_next = (stk_reg[0] == jtgc_pkg::KIND_OBJ) ? PH_KEY
                                                                                : PH_VALUE;
                            end
                        end else if (head.op == jtgc_pkg::OP_CLOSE_OBJ ||
                                     head.op == jtgc_pkg::OP_CLOSE_ARR) begin
                            if (eff_depth != '0 &&
                                stk_reg[0] == (head.op == jtgc_pkg::OP_CLOSE_OBJ)) begin
                                depth_next = eff_depth - DW'(1);
                                stk_next   = {1'b0, stk_reg[MAX_NESTING:1]};
                                ev         = (head.op == jtgc_pkg::OP_CLOSE_OBJ)
                                             ? jtgc_pkg::EV_END_OBJ : jtgc_pkg::EV_END_ARR;
                                phase_next = (eff_depth != DW'(1)) ? PH_AFTER : PH_END;
                            end else begin
                                ok = 1'b0;
                            end
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    PH_END: begin
                        if (head.op == jtgc_pkg::OP_EOF) begin
                            status      = jtgc_pkg::ST_ACCEPTED;
                            active_next = 1'b0;
                            depth_next  = '0;
                            phase_next  = PH_TOP;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    default: ok = 1'b0;
                endcase

                if (!ok) begin
                    ev          = jtgc_pkg::EV_NONE;
                    bv          = 1'b0;
                    emit_text   = 1'b0;
                    status      = jtgc_pkg::ST_ERROR;
                    active_next = 1'b0;
                    depth_next  = '0;
                    phase_next  = PH_TOP;
                end
                m_data_next.event_kind   = ev;
                m_data_next.bool_value   = bv;
                m_data_next.event_offset = emit_text ? head.text_offset : '0;
                m_data_next.event_length = emit_text ? head.text_length : '0;
                m_data_next.parse_status = status;
                m_data_next.open_depth   = 7'(depth_next);
            end else begin
                m_data_next.event_kind   = jtgc_pkg::EV_NONE;
                m_data_next.bool_value   = 1'b0;
                m_data_next.event_offset = '0;
                m_data_next.event_length = '0;
                m_data_next.parse_status = jtgc_pkg::ST_IGNORED;
                m_data_next.open_depth   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TOP;
            depth_reg   <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            depth_reg   <= depth_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
        stk_reg    <= stk_next;
        m_data_reg <= m_data_next;
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_NESTING + 1))
        else $error("nesting depth beyond stack size");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (depth_reg == '0 && phase_reg == PH_TOP))
        else $error("inactive document left state behind");

    a_end_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_END) |-> (depth_reg == '0))
        else $error("top value finished with containers open");

    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_pop && eff_active && !ok) |=>
            (m_valid && m_data.parse_status == jtgc_pkg::ST_ERROR &&
             m_data.event_kind == jtgc_pkg::EV_NONE && !active_reg))
        else $error("error token did not give an error result");

endmodule

// ----- hdl/json_token_grammar_checker.sv -----
`timescale 1ns / 1ps
// json_token_grammar_checker: token stream grammar check with one event per token
// path: a token transfer is written into the queue, then popped into the result register behind m_valid
// throughput: one token per cycle while the result channel is not stalled
// reset: synchronous active-low aresetn empties the queue and result register, clears
// depth, phase and the document flag; the container stack contents are not cleared

module json_token_grammar_checker #(
    parameter int MAX_NESTING = 64   // deepest level at which a value is still taken
) (
    input  logic              aclk,
    input  logic              aresetn,
    // token channel
    input  logic              s_valid,
    output logic              s_ready,
    input  jtgc_pkg::token_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output jtgc_pkg::result_t m_data
);

    // classified token on its way into the queue
    jtgc_pkg::tok_class_t cls;

    // queue head seen by the grammar engine
    jtgc_pkg::tok_class_t head;
    logic                 head_valid;
    logic                 head_pop;

    // front: decode token kind into grammar operation and event template
    jtgc_front u_front (
        .tok (s_data),
        .cls (cls)
    );

    // queue: the token transfer lands here, so the input side keeps moving, until the queue is full,
    // while a result waits on a stalled output
    jtgc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (cls),
        .rd_valid (head_valid),
        .rd_ready (head_pop),
        .rd_data  (head)
    );

    // back: phase register, depth counter and container stack shift line;
    // pops one token per cycle whenever the result register is free or draining
    jtgc_back #(
        .MAX_NESTING (MAX_NESTING)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head       (head),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- bench/tb_json_token_grammar_checker.sv -----
`timescale 1ns / 1ps
// tb_json_token_grammar_checker: self-checking bench for the json token grammar checker
// drives token transfers, predicts each event from its own grammar model and checks them
// depends on jtgc_pkg and json_token_grammar_checker

module tb_json_token_grammar_checker;

    localparam int          MAX_NEST     = 64;     // nesting limit given to the block
    localparam int          ITEM_TARGET  = 1700;   // tokens queued before the run starts
    localparam int          TAIL_QUIET   = 150;    // last tokens sent with no idling
    localparam int          STALL_LIMIT  = 500;    // cycles with no transfer before giving up
    localparam int          DRAIN_CYCLES = 8;      // settle time after the last event
    localparam logic [3:0]  TK_ERROR     = 4'd12;  // lexer error token, not in the package

    // grammar phases of the bench's own parser
    typedef enum logic [2:0] {
        G_TOP,
        G_VALUE,
        G_ARR_OPEN,
        G_OBJ_OPEN,
        G_KEY,
        G_COLON,
        G_AFTER,
        G_DONE
    } gram_phase_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    jtgc_pkg::token_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    jtgc_pkg::result_t m_data;

    json_token_grammar_checker #(
        .MAX_NESTING(MAX_NEST)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // tokens waiting to be sent, and events the block still owes us
    jtgc_pkg::token_t  token_q[$];
    jtgc_pkg::result_t events_due[$];

    // parser state mirrored from the block
    logic        g_stack [0:MAX_NEST];
    int unsigned g_depth  = 0;
    gram_phase_t g_phase  = G_TOP;
    bit          g_active = 1'b0;

    int                tokens_taken = 0;
    int                total_tokens = 0;
    int                src_gap      = 0;
    int                sink_gap     = 0;
    int                stall_cycles = 0;
    int                mismatches   = 0;
    jtgc_pkg::result_t due_now;

    // ---------------------------------------------------------------- prediction

    // a value where one is expected: scalar or the opening of a container
    task automatic take_value(input jtgc_pkg::token_t tok, inout jtgc_pkg::result_t r,
                              inout bit text, output bit ok);
        ok = (g_depth <= MAX_NEST);
        if (ok) begin
            case (tok.token_kind)
                jtgc_pkg::TK_NULL:   r.event_kind = jtgc_pkg::EV_NULL;
                jtgc_pkg::TK_TRUE: begin
                    r.event_kind = jtgc_pkg::EV_BOOL;
                    r.bool_value = 1'b1;
                end
                jtgc_pkg::TK_FALSE:  r.event_kind = jtgc_pkg::EV_BOOL;
                jtgc_pkg::TK_NUMBER: begin
                    r.event_kind = jtgc_pkg::EV_NUMBER;
                    text = 1'b1;
                end
                jtgc_pkg::TK_STRING: begin
                    r.event_kind = jtgc_pkg::EV_STRING;
                    text = 1'b1;
                end
                jtgc_pkg::TK_LBRACE, jtgc_pkg::TK_LBRACK: begin
                    g_stack[g_depth] = (tok.token_kind == jtgc_pkg::TK_LBRACE)
                                       ? jtgc_pkg::KIND_OBJ : jtgc_pkg::KIND_ARR;
                    r.event_kind = (tok.token_kind == jtgc_pkg::TK_LBRACE)
                                   ? jtgc_pkg::EV_BEGIN_OBJ : jtgc_pkg::EV_BEGIN_ARR;
                    g_phase = (tok.token_kind == jtgc_pkg::TK_LBRACE) ? G_OBJ_OPEN
                                                                      : G_ARR_OPEN;
                    g_depth++;
                end
                default: ok = 1'b0;
            endcase
            // a finished scalar moves on to the separator, or to the end at top level
            if (ok && tok.token_kind != jtgc_pkg::TK_LBRACE &&
                tok.token_kind != jtgc_pkg::TK_LBRACK) begin
                g_phase = (g_depth != 0) ? G_AFTER : G_DONE;
            end
        end
    endtask

    // close bracket: must match the innermost open container
    task automatic close_level(input jtgc_pkg::token_t tok, inout jtgc_pkg::result_t r,
                               output bit ok);
        logic want_kind;
        want_kind = (tok.token_kind == jtgc_pkg::TK_RBRACE) ? jtgc_pkg::KIND_OBJ
                                                            : jtgc_pkg::KIND_ARR;
        ok = 1'b0;
        if (g_depth != 0) begin
            if (g_stack[g_depth - 1] == want_kind) begin
                ok = 1'b1;
                g_depth--;
                r.event_kind = (tok.token_kind == jtgc_pkg::TK_RBRACE)
                               ? jtgc_pkg::EV_END_OBJ : jtgc_pkg::EV_END_ARR;
                g_phase = (g_depth != 0) ? G_AFTER : G_DONE;
            end
        end
    endtask

    // one accepted token gives exactly one expected event
    task automatic predict_event(input jtgc_pkg::token_t tok);
        jtgc_pkg::result_t r;
        bit                ok;
        bit                text;
        r    = '0;
        ok   = 1'b1;
        text = 1'b0;
        // start flag restarts the document before the token is looked at
        if (tok.start_doc) begin
            g_depth  = 0;
            g_phase  = G_TOP;
            g_active = 1'b1;
        end
        if (!g_active) begin
            r.parse_status = jtgc_pkg::ST_IGNORED;
        end else begin
            if (tok.token_kind > jtgc_pkg::TK_EOF) begin
                ok = 1'b0;   // lexer error token and unused codes
            end else begin
                case (g_phase)
                    G_TOP, G_VALUE: take_value(tok, r, text, ok);
                    G_ARR_OPEN: begin
                        if (tok.token_kind == jtgc_pkg::TK_RBRACK) close_level(tok, r, ok);
                        else take_value(tok, r, text, ok);
                    end
                    G_OBJ_OPEN, G_KEY: begin
                        // empty object may close at once; after a comma it may not
                        if (tok.token_kind == jtgc_pkg::TK_RBRACE && g_phase == G_OBJ_OPEN) begin
                            close_level(tok, r, ok);
                        end else if (tok.token_kind == jtgc_pkg::TK_STRING) begin
                            r.event_kind = jtgc_pkg::EV_KEY;
                            text = 1'b1;
                            g_phase = G_COLON;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    G_COLON: begin
                        if (tok.token_kind == jtgc_pkg::TK_COLON) g_phase = G_VALUE;
                        else ok = 1'b0;
                    end
                    G_AFTER: begin
                        if (tok.token_kind == jtgc_pkg::TK_COMMA) begin
                            g_phase = (g_stack[g_depth - 1] == jtgc_pkg::KIND_OBJ) ? G_KEY
                                                                                   : G_VALUE;
                        end else if (tok.token_kind == jtgc_pkg::TK_RBRACE ||
                                     tok.token_kind == jtgc_pkg::TK_RBRACK) begin
                            close_level(tok, r, ok);
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    default: begin
                        // top value done: only eof may follow
                        if (tok.token_kind == jtgc_pkg::TK_EOF) begin
                            r.parse_status = jtgc_pkg::ST_ACCEPTED;
                            g_active = 1'b0;
                            g_depth  = 0;
                            g_phase  = G_TOP;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                endcase
            end
            if (!ok) begin
                r = '0;
                r.parse_status = jtgc_pkg::ST_ERROR;
                g_active = 1'b0;
                g_depth  = 0;
                g_phase  = G_TOP;
            end else if (text) begin
                r.event_offset = tok.text_offset;
                r.event_length = tok.text_length;
            end
            r.open_depth = g_depth[6:0];
        end
        events_due.push_back(r);
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // every token carries random text fields, so the zeroing of unused ones is checked too
    function automatic jtgc_pkg::token_t make_tok(input logic [3:0] kind, input bit first);
        jtgc_pkg::token_t t;
        t.token_kind  = kind;
        t.text_offset = rand_word();
        t.text_length = rand_word();
        t.start_doc   = first;
        return t;
    endfunction

    task automatic put(input logic [3:0] kind, input bit first);
        token_q.push_back(make_tok(kind, first));
    endtask

    // one well-formed document, then perhaps broken on purpose
    // dive forces nesting straight down to max_lvl, for the depth limit
    task automatic add_doc(input bit dive, input int max_lvl, input int budget);
        jtgc_pkg::token_t doc[$];
        logic   nest_kind [0:127];
        int     members [0:127];
        int     lvl;
        int     pos;
        bit     want_value;
        bit     deep;
        bit     done;
        lvl        = 0;
        want_value = 1'b1;
        deep       = dive;
        done       = 1'b0;
        while (!done) begin
            if (want_value) begin
                if ((deep && lvl < max_lvl) ||
                    (lvl < max_lvl && budget > 0 && $urandom_range(0, 2) == 0)) begin
                    nest_kind[lvl] = $urandom_range(0, 1) ? jtgc_pkg::KIND_OBJ
                                                          : jtgc_pkg::KIND_ARR;
                    members[lvl]   = 0;
                    doc.push_back(make_tok((nest_kind[lvl] == jtgc_pkg::KIND_OBJ)
                                           ? jtgc_pkg::TK_LBRACE : jtgc_pkg::TK_LBRACK,
                                           doc.size() == 0));
                    lvl++;
                    if (lvl >= max_lvl) deep = 1'b0;
                end else begin
                    deep = 1'b0;
                    doc.push_back(make_tok(4'($urandom_range(jtgc_pkg::TK_NULL,
                                                             jtgc_pkg::TK_STRING)),
                                           doc.size() == 0));
                end
                budget--;
                want_value = 1'b0;
            end else if (lvl == 0) begin
                doc.push_back(make_tok(jtgc_pkg::TK_EOF, 1'b0));
                done = 1'b1;
            end else if (deep || (budget > 0 && $urandom_range(0, 3) != 0)) begin
                // another member: comma, then key and colon inside an object
                if (members[lvl - 1] != 0) doc.push_back(make_tok(jtgc_pkg::TK_COMMA, 1'b0));
                members[lvl - 1]++;
                if (nest_kind[lvl - 1] == jtgc_pkg::KIND_OBJ) begin
                    doc.push_back(make_tok(jtgc_pkg::TK_STRING, 1'b0));
                    doc.push_back(make_tok(jtgc_pkg::TK_COLON, 1'b0));
                end
                want_value = 1'b1;
            end else begin
                lvl--;
                doc.push_back(make_tok((nest_kind[lvl] == jtgc_pkg::KIND_OBJ)
                                       ? jtgc_pkg::TK_RBRACE : jtgc_pkg::TK_RBRACK, 1'b0));
            end
        end
        // about two in five of the documents get one fault
        if (doc.size() > 1) begin
            pos = $urandom_range(1, doc.size() - 1);
            case ($urandom_range(0, 9))
                0: doc[pos].token_kind = 4'($urandom_range(0, 15));
                1: doc.delete(pos);
                2: doc.insert(pos, make_tok(4'($urandom_range(0, 15)), 1'b0));
                3: doc[pos].start_doc = 1'b1;
                default: ;
            endcase
        end
        foreach (doc[i]) token_q.push_back(doc[i]);
    endtask

    // idling is kept out of every fourth window and out of the tail of the run
    function automatic bit idle_ok();
        return (tokens_taken + TAIL_QUIET < total_tokens) && ((tokens_taken / 128) % 4 != 3);
    endfunction

    // ---------------------------------------------------------------- token driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            // a transfer this edge is what the model steps on
            if (s_valid && s_ready) begin
                predict_event(s_data);
                tokens_taken++;
            end
            // the slot is free when nothing is shown or the shown token just left
            if (!s_valid || s_ready) begin
                if (src_gap == 0 && idle_ok() && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 15);
                end
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (token_q.size() != 0) begin
                    s_data  <= token_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- event monitor

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    $display("%0t: event transfer with no token behind it, got %0h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    due_now = events_due.pop_front();
                    if (m_data.event_kind != due_now.event_kind)
                        note_mismatch("event_kind", 32'(due_now.event_kind),
                                      32'(m_data.event_kind));
                    if (m_data.bool_value != due_now.bool_value)
                        note_mismatch("bool_value", 32'(due_now.bool_value),
                                      32'(m_data.bool_value));
                    if (m_data.event_offset != due_now.event_offset)
                        note_mismatch("event_offset", due_now.event_offset, m_data.event_offset);
                    if (m_data.event_length != due_now.event_length)
                        note_mismatch("event_length", due_now.event_length, m_data.event_length);
                    if (m_data.parse_status != due_now.parse_status)
                        note_mismatch("parse_status", 32'(due_now.parse_status),
                                      32'(m_data.parse_status));
                    if (m_data.open_depth != due_now.open_depth)
                        note_mismatch("open_depth", 32'(due_now.open_depth),
                                      32'(m_data.open_depth));
                end
            end
            // back-pressure in random bursts
            if (sink_gap == 0 && idle_ok() && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(1, 15);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_json_token_grammar_checker: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // token with no document open yet
        put(jtgc_pkg::TK_NULL, 1'b0);
        // scalar document with extreme text fields
        put(jtgc_pkg::TK_NUMBER, 1'b1);
        token_q[$].text_offset = 32'h0000_0000;
        token_q[$].text_length = 32'hFFFF_FFFF;
        put(jtgc_pkg::TK_EOF, 1'b0);
        // object holding an array of booleans
        put(jtgc_pkg::TK_LBRACE, 1'b1);
        put(jtgc_pkg::TK_STRING, 1'b0);
        token_q[$].text_offset = 32'hFFFF_FFFF;
        token_q[$].text_length = 32'h0000_0000;
        put(jtgc_pkg::TK_COLON, 1'b0);
        put(jtgc_pkg::TK_LBRACK, 1'b0);
        put(jtgc_pkg::TK_TRUE, 1'b0);
        put(jtgc_pkg::TK_COMMA, 1'b0);
        put(jtgc_pkg::TK_FALSE, 1'b0);
        put(jtgc_pkg::TK_RBRACK, 1'b0);
        put(jtgc_pkg::TK_RBRACE, 1'b0);
        put(jtgc_pkg::TK_EOF, 1'b0);
        // empty object
        put(jtgc_pkg::TK_LBRACE, 1'b1);
        put(jtgc_pkg::TK_RBRACE, 1'b0);
        put(jtgc_pkg::TK_EOF, 1'b0);
        // trailing comma
        put(jtgc_pkg::TK_LBRACK, 1'b1);
        put(jtgc_pkg::TK_NUMBER, 1'b0);
        put(jtgc_pkg::TK_COMMA, 1'b0);
        put(jtgc_pkg::TK_RBRACK, 1'b0);
        // lexer error token
        put(TK_ERROR, 1'b1);
        // key that is not a string
        put(jtgc_pkg::TK_LBRACE, 1'b1);
        put(jtgc_pkg::TK_NUMBER, 1'b0);
        // missing comma
        put(jtgc_pkg::TK_LBRACK, 1'b1);
        put(jtgc_pkg::TK_NULL, 1'b0);
        put(jtgc_pkg::TK_NULL, 1'b0);
        // missing colon
        put(jtgc_pkg::TK_LBRACE, 1'b1);
        put(jtgc_pkg::TK_STRING, 1'b0);
        put(jtgc_pkg::TK_NULL, 1'b0);
        // close that does not match, then a token after the document died
        put(jtgc_pkg::TK_LBRACK, 1'b1);
        put(jtgc_pkg::TK_RBRACE, 1'b0);
        put(jtgc_pkg::TK_FALSE, 1'b0);
        // junk after the top value
        put(jtgc_pkg::TK_TRUE, 1'b1);
        put(jtgc_pkg::TK_TRUE, 1'b0);

        // one dive past the nesting limit up front, then a mix
        add_doc(1'b1, MAX_NEST + 2, MAX_NEST + 4);
        while (token_q.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 11) == 0) begin
                // raw noise, any code, occasionally with a start flag
                repeat ($urandom_range(1, 6)) begin
                    put(4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
                end
            end else if ($urandom_range(0, 79) == 0) begin
                int lim;
                lim = $urandom_range(MAX_NEST - 1, MAX_NEST + 2);
                add_doc(1'b1, lim, lim + $urandom_range(0, 3));
            end else begin
                add_doc(1'b0, $urandom_range(1, 6), $urandom_range(1, 12));
            end
        end
        total_tokens = token_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // every token sent, every event in, then a short settle for strays
        while (token_q.size() != 0 || s_valid) @(posedge aclk);
        while (events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_json_token_grammar_checker: done, clean");
        end else begin
            $display("tb_json_token_grammar_checker: done, errors");
        end
        $finish;
    end

endmodule
